// ----- hw/rtl/sat_pkg.sv -----
`default_nettype none
package sat_pkg;

  localparam int unsigned SAT_SLOTS        = 16;
  localparam int unsigned SAT_ADDRESS_BITS = 32;
  localparam logic [31:0] SAT_MAX_SIZE_RST = 32'd64;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_LOAD      = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BOUNDS = 2'd1,
    STATUS_NO_SEG = 2'd2
  } sat_status_e;

  typedef struct packed {
    logic        en;
    logic [7:0]  slot;
    logic [7:0]  id;
    logic [31:0] base;
    logic [31:0] size;
    logic        in_use;
  } sat_wr_t;

  typedef struct packed {
    logic        valid;
    logic        key_ok;
    logic [7:0]  key;
    logic        found;
    logic [31:0] base;
    logic [31:0] size;
  } sat_token_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sat_req_if.sv -----
`default_nettype none
interface sat_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] logical_address;
  logic [15:0] byte_count;
  logic [3:0]  entry_slot;
  logic [7:0]  entry_id;
  logic [31:0] entry_base;
  logic [31:0] entry_size;
  logic        entry_valid;

  modport source (
    output valid, req_type, logical_address, byte_count, entry_slot,
           entry_id, entry_base, entry_size, entry_valid,
    input  ready
  );

  modport sink (
    input  valid, req_type, logical_address, byte_count, entry_slot,
           entry_id, entry_base, entry_size, entry_valid,
    output ready
  );
endinterface
`default_nettype wire

// ----- hw/rtl/sat_rsp_if.sv -----
`default_nettype none
interface sat_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] physical_address;
  logic [31:0] segment_number;
  logic [1:0]  status;

  modport source (
    output valid, physical_address, segment_number, status,
    input  ready
  );

  modport sink (
    input  valid, physical_address, segment_number, status,
    output ready
  );
endinterface
`default_nettype wire

// ----- hw/rtl/sat_divider.sv -----
`default_nettype none
module sat_divider #(
  parameter int unsigned DW = sat_pkg::SAT_ADDRESS_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [31:0]   divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o,
  output logic [31:0]        remainder_o
);

  localparam int unsigned CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   div_q, div_d;
  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          take;

  always_comb begin
    trial = {rem_q, dvd_q[DW-1]};
    diff  = trial - {1'b0, div_q};
    take  = (trial >= {1'b0, div_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = take ? diff[31:0] : trial[31:0];
      dvd_d = {dvd_q[DW-2:0], take};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

// ----- hw/rtl/sat_cell.sv -----
`default_nettype none
module sat_cell #(
  parameter int unsigned SLOT_IDX = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sat_pkg::sat_wr_t    wr_i,
  input  wire sat_pkg::sat_token_t tok_i,
  output sat_pkg::sat_token_t      tok_o
);

  logic                in_use_q;
  logic [7:0]          id_q;
  logic [31:0]         base_q;
  logic [31:0]         size_q;
  logic                wr_hit;
  logic                match;
  sat_pkg::sat_token_t tok_d, tok_q;

  assign wr_hit = wr_i.en && (wr_i.slot == 8'(SLOT_IDX));
  assign match  = tok_i.key_ok && in_use_q && (id_q == tok_i.key);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.found && match) begin
      tok_d.found = 1'b1;
      tok_d.base  = base_q;
      tok_d.size  = size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      if (wr_hit) begin
        in_use_q <= wr_i.in_use;
      end
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      id_q   <= wr_i.id;
      base_q <= wr_i.base;
      size_q <= wr_i.size;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

// ----- hw/rtl/segment_address_translator.sv -----
`default_nettype none
// Segmentation address translator. A load word writes one segment slot and is
// answered in the cycle after acceptance with status ok. A translate word
// splits the logical address by max_segment_size in a restoring divider that
// takes one cycle per address bit, then sends a lookup token down a row of
// SEGMENT_SLOTS cells, one cell per cycle, where the first in-use slot with a
// matching id wins; as the token leaves the last cell, bounds are checked and
// base plus offset is formed into the response registers. One word is in
// flight at a time; the next word is taken once the result has been taken.
// Write max_segment_size only while idle.
module segment_address_translator #(
  parameter int unsigned SEGMENT_SLOTS = sat_pkg::SAT_SLOTS,
  parameter int unsigned ADDRESS_BITS  = sat_pkg::SAT_ADDRESS_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  sat_req_if.sink          req_i,
  sat_rsp_if.source        rsp_o
);

  localparam int unsigned DW = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [31:0]           max_size_q;
  logic                  accept;
  logic                  div_start;
  logic                  div_done;
  logic [DW-1:0]         quotient;
  logic [31:0]           remainder;
  logic [DW-1:0]         la_q;
  logic [15:0]           count_q;
  logic                  div_zero_q;
  logic [31:0]           offset;
  logic [31:0]           segnum;
  logic [32:0]           end_sum;
  logic [32:0]           phys_sum;
  sat_pkg::sat_wr_t      wr;
  sat_pkg::sat_token_t   tok [SEGMENT_SLOTS+1];
  sat_pkg::sat_token_t   tail;
  logic [31:0]           phys_q, phys_d;
  logic [31:0]           seg_q, seg_d;
  sat_pkg::sat_status_e  status_q, status_d;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign div_start   = accept && (req_i.req_type == sat_pkg::REQ_TRANSLATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= sat_pkg::SAT_MAX_SIZE_RST;
    end else if (cfg_we_i) begin
      max_size_q <= cfg_wdata_i;
    end
  end

  sat_divider #(
    .DW (DW)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (req_i.logical_address[DW-1:0]),
    .divisor_i   (max_size_q),
    .done_o      (div_done),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      la_q       <= req_i.logical_address[DW-1:0];
      count_q    <= req_i.byte_count;
      div_zero_q <= (max_size_q == 32'd0);
    end
  end

  always_comb begin
    wr.en     = accept && (req_i.req_type == sat_pkg::REQ_LOAD);
    wr.slot   = 8'(req_i.entry_slot);
    wr.id     = req_i.entry_id;
    wr.base   = req_i.entry_base;
    wr.size   = req_i.entry_size;
    wr.in_use = req_i.entry_valid;
  end

  // launch the lookup token into the first cell
  always_comb begin
    tok[0].valid  = (state_q == ST_DIV) && div_done;
    tok[0].key_ok = !div_zero_q && ((quotient >> 8) == '0);
    tok[0].key    = quotient[7:0];
    tok[0].found  = 1'b0;
    tok[0].base   = '0;
    tok[0].size   = '0;
  end

  for (genvar i = 0; i < SEGMENT_SLOTS; i++) begin : g_cell
    sat_cell #(
      .SLOT_IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  assign tail     = tok[SEGMENT_SLOTS];
  assign offset   = div_zero_q ? 32'(la_q) : remainder;
  assign segnum   = div_zero_q ? '1 : 32'(quotient);
  assign end_sum  = {1'b0, offset} + 33'(count_q);
  assign phys_sum = {1'b0, tail.base} + {1'b0, offset};

  always_comb begin
    state_d  = state_q;
    phys_d   = phys_q;
    seg_d    = seg_q;
    status_d = status_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.req_type == sat_pkg::REQ_LOAD) begin
            phys_d   = '0;
            seg_d    = '0;
            status_d = sat_pkg::STATUS_OK;
            state_d  = ST_RESP;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail.valid) begin
          seg_d  = segnum;
          phys_d = '0;
          if (!tail.found) begin
            status_d = sat_pkg::STATUS_NO_SEG;
          end else if (end_sum > {1'b0, tail.size}) begin
            status_d = sat_pkg::STATUS_BOUNDS;
          end else begin
            status_d = sat_pkg::STATUS_OK;
            phys_d   = 32'(phys_sum[DW-1:0]);
          end
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phys_q   <= phys_d;
    seg_q    <= seg_d;
    status_q <= status_d;
  end

  assign rsp_o.valid            = (state_q == ST_RESP);
  assign rsp_o.physical_address = phys_q;
  assign rsp_o.segment_number   = seg_q;
  assign rsp_o.status           = status_q;

endmodule
`default_nettype wire
